@@ sv/nearest_neighbor_pixel_scaler_unit_assert.svh @@
// Assertion macros shared by the scaler modules.
`ifndef NEAREST_NEIGHBOR_PIXEL_SCALER_UNIT_ASSERT_SVH
`define NEAREST_NEIGHBOR_PIXEL_SCALER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define NNPS_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("scaler assertion failed");
`define NNPS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("scaler assertion failed");
`else
`define NNPS_ASSERT(label, clk, rst_n, expr)
`define NNPS_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

@@ sv/nnps_pkg.sv @@
package nnps_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_FACTOR = 64;
    localparam int HEIGHT_LIMIT = 4096;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int DIM_W  = 13;
    localparam int FACT_W = 7;
    localparam int PH_W   = $clog2(MAX_FACTOR);
    localparam int OCOL_W = 19;
    localparam int PIX_W  = 24;
    localparam int PAD_W  = 2;
    localparam int CFG_W  = 13;

    localparam int DIV_STEPS = DIM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_MODE   = 2'd0,
        CFG_FACTOR = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              mode;
        logic [FACT_W-1:0] factor;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  wout_dn;
        logic [DIM_W-1:0]  hout_dn;
        logic [OCOL_W-1:0] wout_up_m1;
        logic              busy;
    } t_cfg;

    typedef struct packed {
        logic             took;
        logic             valid;
        logic [PIX_W-1:0] pixel;
        logic [PAD_W-1:0] pad;
        logic             row_end;
        logic             image_end;
    } t_res;

endpackage

@@ sv/nnps_setup.sv @@
module nnps_setup (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  nnps_pkg::t_cfg_idx             i_addr,
    input  logic [nnps_pkg::CFG_W-1:0]     i_data,
    output nnps_pkg::t_cfg                 o_cfg
);
    import nnps_pkg::*;

    logic              r_mode;
    logic [FACT_W-1:0] r_factor;
    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic              r_load;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic [DIM_W-1:0]  r_qw, r_qh;
    logic [FACT_W-1:0] r_rw, r_rh;
    logic [OCOL_W-1:0] r_wup_m1;

    logic [DIM_W-1:0]  n_qw, n_qh;
    logic [FACT_W-1:0] n_rw, n_rh;
    logic [FACT_W:0]   w_trial, h_trial;
    logic [FACT_W:0]   w_div;

    function automatic logic [FACT_W-1:0] clamp_factor(input logic [FACT_W-1:0] v);
        logic [FACT_W-1:0] r;
        r = v;
        if (v == '0) r = FACT_W'(1);
        else if (v > FACT_W'(MAX_FACTOR)) r = FACT_W'(MAX_FACTOR);
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        else if (v > lim) r = lim;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_factor <= FACT_W'(1);
            r_width  <= DIM_W'(1);
            r_height <= DIM_W'(1);
            r_load   <= 1'b1;
            r_busy   <= 1'b1;
            r_step   <= '0;
        end else if (i_we) begin
            case (i_addr)
                CFG_MODE:   r_mode   <= i_data[0];
                CFG_FACTOR: r_factor <= clamp_factor(i_data[FACT_W-1:0]);
                CFG_WIDTH:  r_width  <= clamp_dim(i_data[DIM_W-1:0], DIM_W'(MAX_WIDTH));
                CFG_HEIGHT: r_height <= clamp_dim(i_data[DIM_W-1:0], DIM_W'(HEIGHT_LIMIT));
                default: ;
            endcase
            r_load <= 1'b1;
            r_busy <= 1'b1;
        end else if (r_load) begin
            r_load <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_comb begin
        w_div   = {1'b0, r_factor};
        w_trial = {r_rw, r_qw[DIM_W-1]};
        h_trial = {r_rh, r_qh[DIM_W-1]};
        if (w_trial >= w_div) begin
            n_rw = FACT_W'(w_trial - w_div);
            n_qw = {r_qw[DIM_W-2:0], 1'b1};
        end else begin
            n_rw = w_trial[FACT_W-1:0];
            n_qw = {r_qw[DIM_W-2:0], 1'b0};
        end
        if (h_trial >= w_div) begin
            n_rh = FACT_W'(h_trial - w_div);
            n_qh = {r_qh[DIM_W-2:0], 1'b1};
        end else begin
            n_rh = h_trial[FACT_W-1:0];
            n_qh = {r_qh[DIM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_qw <= r_width;
            r_qh <= r_height;
            r_rw <= '0;
            r_rh <= '0;
        end else if (r_busy) begin
            r_qw <= n_qw;
            r_qh <= n_qh;
            r_rw <= n_rw;
            r_rh <= n_rh;
        end
        r_wup_m1 <= OCOL_W'(r_width) * OCOL_W'(r_factor) - OCOL_W'(1);
    end

    assign o_cfg.mode       = r_mode;
    assign o_cfg.factor     = r_factor;
    assign o_cfg.width      = r_width;
    assign o_cfg.height     = r_height;
    assign o_cfg.wout_dn    = r_qw;
    assign o_cfg.hout_dn    = r_qh;
    assign o_cfg.wout_up_m1 = r_wup_m1;
    assign o_cfg.busy       = r_busy;

endmodule

@@ sv/nnps_front.sv @@
module nnps_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nnps_pkg::t_cfg                  i_cfg,
    input  logic                            i_restart,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  nnps_pkg::t_op                   i_op,
    input  logic [nnps_pkg::PIX_W-1:0]      i_pixel,
    input  logic [nnps_pkg::QCNT_W-1:0]     i_q_count,
    output logic                            o_push,
    output nnps_pkg::t_res                  o_item
);
    import nnps_pkg::*;

    `include "nearest_neighbor_pixel_scaler_unit_assert.svh"

    typedef struct packed {
        logic             took;
        logic             valid;
        logic             from_mem;
        logic [PIX_W-1:0] pixel;
        logic [PAD_W-1:0] pad;
        logic             row_end;
        logic             image_end;
    } t_desc;

    logic [COL_W-1:0]  r_in_col, n_in_col;
    logic [COL_W-1:0]  r_in_row, n_in_row;
    logic [COL_W-1:0]  r_orow, n_orow;
    logic [OCOL_W-1:0] r_out_col, n_out_col;
    logic [PH_W-1:0]   r_col_ph, n_col_ph;
    logic [PH_W-1:0]   r_row_ph, n_row_ph;
    logic              r_replay, n_replay;
    logic              r_s1_valid;
    t_desc             r_s1, d;
    logic [PIX_W-1:0]  r_line [MAX_WIDTH];
    logic [PIX_W-1:0]  r_rd_data;

    logic              accept;
    logic              mem_we, mem_re;
    logic [DIM_W-1:0]  c_col_inc, c_row_inc;
    logic [FACT_W-1:0] c_cph_inc, c_rph_inc;
    logic [OCOL_W-1:0] c_ocol_inc;

    assign o_ready = !i_cfg.busy &&
                     ((i_q_count + QCNT_W'(r_s1_valid)) < QCNT_W'(QDEPTH));
    assign accept  = i_valid && o_ready;

    always_comb begin
        c_col_inc  = {1'b0, r_in_col} + DIM_W'(1);
        c_row_inc  = {1'b0, r_in_row} + DIM_W'(1);
        c_cph_inc  = {1'b0, r_col_ph} + FACT_W'(1);
        c_rph_inc  = {1'b0, r_row_ph} + FACT_W'(1);
        c_ocol_inc = r_out_col + OCOL_W'(1);

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_orow    = r_orow;
        n_out_col = r_out_col;
        n_col_ph  = r_col_ph;
        n_row_ph  = r_row_ph;
        n_replay  = r_replay;
        d         = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;

        if (accept) begin
            if (i_cfg.mode) begin
                if (i_op == OP_PIXEL) begin
                    d.took = 1'b1;
                    if (r_row_ph == '0 && r_col_ph == '0 &&
                        r_out_col < OCOL_W'(i_cfg.wout_dn) &&
                        {1'b0, r_orow} < i_cfg.hout_dn) begin
                        d.valid   = 1'b1;
                        d.pixel   = i_pixel;
                        n_out_col = c_ocol_inc;
                        if (c_ocol_inc == OCOL_W'(i_cfg.wout_dn)) begin
                            d.pad       = i_cfg.wout_dn[PAD_W-1:0];
                            d.row_end   = 1'b1;
                            d.image_end = ({1'b0, r_orow} == i_cfg.hout_dn - DIM_W'(1));
                        end
                    end
                    n_col_ph = (c_cph_inc >= i_cfg.factor) ? '0 : c_cph_inc[PH_W-1:0];
                    if (c_col_inc >= i_cfg.width) begin
                        n_in_col  = '0;
                        n_col_ph  = '0;
                        n_out_col = '0;
                        if (c_rph_inc >= i_cfg.factor) begin
                            n_row_ph = '0;
                            n_orow   = r_orow + COL_W'(1);
                        end else begin
                            n_row_ph = c_rph_inc[PH_W-1:0];
                        end
                        if (c_row_inc >= i_cfg.height) begin
                            n_in_row = '0;
                            n_row_ph = '0;
                            n_orow   = '0;
                        end else begin
                            n_in_row = c_row_inc[COL_W-1:0];
                        end
                    end else begin
                        n_in_col = c_col_inc[COL_W-1:0];
                    end
                end
            end else if (!r_replay) begin
                if (i_op == OP_PIXEL) begin
                    d.took = 1'b1;
                    mem_we = 1'b1;
                    if (c_col_inc >= i_cfg.width) begin
                        n_in_col  = '0;
                        n_out_col = '0;
                        n_col_ph  = '0;
                        n_row_ph  = '0;
                        n_replay  = 1'b1;
                    end else begin
                        n_in_col = c_col_inc[COL_W-1:0];
                    end
                end
            end else if (i_op == OP_TICK) begin
                d.valid    = 1'b1;
                d.from_mem = 1'b1;
                mem_re     = 1'b1;
                if (c_cph_inc >= i_cfg.factor) begin
                    n_col_ph = '0;
                    n_in_col = c_col_inc[COL_W-1:0];
                end else begin
                    n_col_ph = c_cph_inc[PH_W-1:0];
                end
                if (r_out_col >= i_cfg.wout_up_m1) begin
                    d.pad     = i_cfg.wout_up_m1[PAD_W-1:0] + PAD_W'(1);
                    d.row_end = 1'b1;
                    n_in_col  = '0;
                    n_out_col = '0;
                    n_col_ph  = '0;
                    if ({1'b0, r_row_ph} >= i_cfg.factor - FACT_W'(1)) begin
                        n_row_ph = '0;
                        n_replay = 1'b0;
                        if ({1'b0, r_in_row} >= i_cfg.height - DIM_W'(1)) begin
                            d.image_end = 1'b1;
                            n_in_row    = '0;
                        end else begin
                            n_in_row = c_row_inc[COL_W-1:0];
                        end
                    end else begin
                        n_row_ph = c_rph_inc[PH_W-1:0];
                    end
                end else begin
                    n_out_col = c_ocol_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_orow    <= '0;
            r_out_col <= '0;
            r_col_ph  <= '0;
            r_row_ph  <= '0;
            r_replay  <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_orow    <= n_orow;
            r_out_col <= n_out_col;
            r_col_ph  <= n_col_ph;
            r_row_ph  <= n_row_ph;
            r_replay  <= n_replay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_line[r_in_col] <= i_pixel;
        end
        if (mem_re) begin
            r_rd_data <= r_line[r_in_col];
        end
    end

    assign o_push           = r_s1_valid;
    assign o_item.took      = r_s1.took;
    assign o_item.valid     = r_s1.valid;
    assign o_item.pixel     = r_s1.from_mem ? r_rd_data : r_s1.pixel;
    assign o_item.pad       = r_s1.pad;
    assign o_item.row_end   = r_s1.row_end;
    assign o_item.image_end = r_s1.image_end;

    `NNPS_ASSERT_NEXT(a_tick_reads_line, i_clk, i_rst_n, accept && !i_cfg.mode && r_replay && i_op == OP_TICK && !i_restart, r_s1_valid && r_s1.from_mem)
    `NNPS_ASSERT(a_fill_after_row_end, i_clk, i_rst_n, !$fell(r_replay) || $past(i_restart) || (r_s1_valid && r_s1.row_end))

endmodule

@@ sv/nnps_fifo.sv @@
module nnps_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  nnps_pkg::t_res                  i_item,
    output logic [nnps_pkg::QCNT_W-1:0]     o_count,
    output logic                            o_valid,
    input  logic                            i_ready,
    output nnps_pkg::t_res                  o_item
);
    import nnps_pkg::*;

    `include "nearest_neighbor_pixel_scaler_unit_assert.svh"

    t_res              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_count = r_count;
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (pop)    r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    `NNPS_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && !pop && r_count == QCNT_W'(QDEPTH)))

endmodule

@@ sv/nearest_neighbor_pixel_scaler_unit.sv @@
// Channel  | Dir | Handshake               | Payload
// s_axis   | in  | tvalid / tready         | tdata: blue, green, red; tuser: opcode
// m_axis   | out | tvalid / tready         | tdata: blue, green, red, pad; tlast: row_end;
//          |     |                         | tuser: took_pixel, out_valid, image_end
// cfg      | in  | we (no wait)            | addr: register index; data: value
//
// One beat in, one beat out; a beat is accepted every cycle while setup is idle
// and the queue has room; its result leaves through a stage register and a
// four-entry queue. Reset and every register write start a setup (two
// bit-per-cycle dividers for the shrink sizes); s_axis tready is low meanwhile.
// The line buffer is a single-port memory: the fill writes it, replay ticks
// read it. A stall on m_axis fills the queue and then drops s_axis tready.
module nearest_neighbor_pixel_scaler_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // blue[7:0], green[15:8], red[23:16]
    input  logic        i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // blue, green, red, pad_bytes[25:24], zero
    output logic        o_m_axis_tlast,   // row_end
    output logic [2:0]  o_m_axis_tuser,   // took_pixel, out_valid, image_end
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_data
);
    import nnps_pkg::*;

    t_cfg              cfg;
    t_res              push_item;
    t_res              out_item;
    logic              push;
    logic [QCNT_W-1:0] q_count;

    nnps_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (t_cfg_idx'(i_cfg_addr)),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    nnps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_restart (i_cfg_we),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_op      (t_op'(i_s_axis_tuser)),
        .i_pixel   (i_s_axis_tdata),
        .i_q_count (q_count),
        .o_push    (push),
        .o_item    (push_item)
    );

    nnps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_count (q_count),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_item  (out_item)
    );

    assign o_m_axis_tdata = {6'd0, out_item.pad, out_item.pixel};
    assign o_m_axis_tlast = out_item.row_end;
    assign o_m_axis_tuser = {out_item.image_end, out_item.valid, out_item.took};

endmodule
